// ===== rtl/rrqs_pkg.sv =====
package rrqs_pkg;

    localparam int unsigned ID_W    = 16;
    localparam int unsigned BURST_W = 16;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned SUM_W   = 32;
    localparam int unsigned CNT_W   = 16;
    localparam int unsigned QNT_W   = 16;

    localparam logic OP_ARRIVE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    localparam logic [1:0] STATUS_QUEUED  = 2'd0;
    localparam logic [1:0] STATUS_DROPPED = 2'd1;
    localparam logic [1:0] STATUS_IDLE    = 2'd2;
    localparam logic [1:0] STATUS_RAN     = 2'd3;

    localparam logic [QNT_W-1:0] QUANTUM_RESET = 16'd1;

    // one queued job
    typedef struct packed {
        logic [ID_W-1:0]    job_id;
        logic [TIME_W-1:0]  arrival;
        logic [BURST_W-1:0] burst;
        logic [BURST_W-1:0] remaining;
        logic               started;
    } entry_t;

    // per-cell controls
    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctrl_t;

endpackage

// ===== rtl/rrqs_cell.sv =====
module rrqs_cell
(
    input  logic                clk,
    input  rrqs_pkg::cell_ctrl_t ctrl,
    input  rrqs_pkg::entry_t    load_entry,
    input  rrqs_pkg::entry_t    neighbor_entry,
    output rrqs_pkg::entry_t    entry
);

    rrqs_pkg::entry_t entry_reg;
    rrqs_pkg::entry_t entry_next;

    always_comb
    begin
        priority if (ctrl.load)
        begin
            entry_next = load_entry;
        end
        else if (ctrl.shift)
        begin
            entry_next = neighbor_entry;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ===== rtl/rrqs_chain.sv =====
module rrqs_chain
#(
    parameter int unsigned QUEUE_DEPTH = 64
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    input  logic                                 pop,
    input  rrqs_pkg::entry_t                     push_entry,
    output rrqs_pkg::entry_t                     head_entry,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]     count
);

    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    rrqs_pkg::entry_t     cell_q   [QUEUE_DEPTH];
    rrqs_pkg::entry_t     cell_nb  [QUEUE_DEPTH];
    rrqs_pkg::cell_ctrl_t cell_ctl [QUEUE_DEPTH];

    // head sits in cell 0, a pop moves every entry one cell toward it
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign cell_nb[i] = cell_q[i];
        end
        else
        begin : g_mid
            assign cell_nb[i] = cell_q[i+1];
        end

        assign cell_ctl[i].shift = pop;
        assign cell_ctl[i].load  = push && (count_reg == CW'(i));

        rrqs_cell u_cell
        (
            .clk            (clk),
            .ctrl           (cell_ctl[i]),
            .load_entry     (push_entry),
            .neighbor_entry (cell_nb[i]),
            .entry          (cell_q[i])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        if (push)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign head_entry = cell_q[0];
    assign count      = count_reg;

endmodule

// ===== rtl/round_robin_quantum_scheduler.sv =====
// round-robin scheduler with a time quantum
// input stream (s_*): one transaction per event. s_tuser is the op: arrival
// queues a job (job_id, burst) at the tail of the ready queue, tick advances
// time by one and serves the running job for one unit.
// output stream (m_*): exactly one result transaction per input transaction,
// carrying status, the served job, the flags and the running totals.
// quantum is written through cfg_we / cfg_wdata; the user must write it only
// while the block is idle, the block itself does not enforce this. the ready
// queue is a row of QUEUE_DEPTH cells; the head lives in cell 0 and a pop
// shifts every cell one place toward it, a push loads the cell at the fill
// count. an accepted arrival goes through the item registers to the output
// register; a tick first picks the job and forms the deltas, then serves and
// requeues. the next item is accepted in the cycle its predecessor reaches
// the output register, so arrivals sustain one per cycle while the receiver
// does not stall. when it stalls, the result waits in the output register
// and the block holds the following item until that register frees up.
// reset empties the queue, clears time and totals, and sets quantum to 1.
module round_robin_quantum_scheduler
#(
    parameter int unsigned QUEUE_DEPTH = 64
)
(
    input  logic         clk,
    input  logic         rst_n,
    // config
    input  logic         cfg_we,
    input  logic [15:0]  cfg_wdata,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // job_id[15:0], burst[31:16]
    input  logic         s_tuser,   // op
    // output stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // ran_id[15:0], finished[16], preempted[17], time_now[49:18],
    // total_waiting[81:50], total_response[113:82], completed_count[129:114]
    output logic [135:0] m_tdata,
    output logic [1:0]   m_tuser    // status
);

    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_PICK,
        PH_SERVE
    } phase_t;

    phase_t phase_reg;
    phase_t phase_next;

    logic                          item_op_reg;
    logic [rrqs_pkg::ID_W-1:0]     item_id_reg;
    logic [rrqs_pkg::BURST_W-1:0]  item_burst_reg;

    logic [rrqs_pkg::QNT_W-1:0]    quantum_reg;
    logic                          run_valid_reg;
    logic                          run_valid_next;
    rrqs_pkg::entry_t              run_reg;
    rrqs_pkg::entry_t              run_next;
    logic [rrqs_pkg::QNT_W-1:0]    slice_reg;
    logic [rrqs_pkg::QNT_W-1:0]    slice_next;
    logic [rrqs_pkg::TIME_W-1:0]   time_reg;
    logic [rrqs_pkg::TIME_W-1:0]   time_next;
    logic [rrqs_pkg::SUM_W-1:0]    wsum_reg;
    logic [rrqs_pkg::SUM_W-1:0]    wsum_next;
    logic [rrqs_pkg::SUM_W-1:0]    rsum_reg;
    logic [rrqs_pkg::SUM_W-1:0]    rsum_next;
    logic [rrqs_pkg::CNT_W-1:0]    done_reg;
    logic [rrqs_pkg::CNT_W-1:0]    done_next;

    // values formed in the pick cycle
    logic                          serve_reg;
    logic [rrqs_pkg::SUM_W-1:0]    resp_delta_reg;
    logic [rrqs_pkg::SUM_W-1:0]    wait_delta_reg;
    logic [rrqs_pkg::BURST_W-1:0]  rem_dec_reg;
    logic [rrqs_pkg::QNT_W-1:0]    slice_inc_reg;

    logic                          m_tvalid_reg;
    logic                          m_tvalid_next;
    logic [135:0]                  m_tdata_reg;
    logic [135:0]                  m_tdata_next;
    logic [1:0]                    m_tuser_reg;
    logic [1:0]                    m_tuser_next;

    rrqs_pkg::entry_t              head_entry;
    rrqs_pkg::entry_t              sel_entry;
    rrqs_pkg::entry_t              arr_entry;
    rrqs_pkg::entry_t              requeue_entry;
    rrqs_pkg::entry_t              push_entry;
    logic [CW-1:0]                 q_count;

    logic                          q_empty;
    logic                          q_full;
    logic                          in_fire;
    logic                          out_free;
    logic                          is_arr;
    logic                          arr_done;
    logic                          serve_done;
    logic                          need_pop;
    logic                          have_job;
    logic                          fin;
    logic                          expire;
    logic                          requeue;
    logic                          push;
    logic [rrqs_pkg::BURST_W-1:0]  arr_burst;
    logic [rrqs_pkg::ID_W-1:0]     ran_id;

    assign q_empty    = (q_count == '0);
    assign q_full     = (q_count == CW'(QUEUE_DEPTH));
    assign out_free   = !m_tvalid_reg || m_tready;
    assign is_arr     = (item_op_reg == rrqs_pkg::OP_ARRIVE);
    assign arr_done   = (phase_reg == PH_PICK) && is_arr && out_free;
    assign serve_done = (phase_reg == PH_SERVE) && out_free;
    assign s_tready   = (phase_reg == PH_IDLE) || arr_done || serve_done;
    assign in_fire    = s_tvalid && s_tready;

    assign need_pop  = (phase_reg == PH_PICK) && !is_arr && !run_valid_reg && !q_empty;
    assign have_job  = run_valid_reg || !q_empty;
    assign sel_entry = run_valid_reg ? run_reg : head_entry;

    assign arr_burst = (item_burst_reg == '0) ? rrqs_pkg::BURST_W'(1) : item_burst_reg;
    assign arr_entry = '{job_id:    item_id_reg,
                         arrival:   time_reg,
                         burst:     arr_burst,
                         remaining: arr_burst,
                         started:   1'b0};
    assign requeue_entry = '{job_id:    run_reg.job_id,
                             arrival:   run_reg.arrival,
                             burst:     run_reg.burst,
                             remaining: rem_dec_reg,
                             started:   1'b1};

    assign fin     = serve_reg && (rem_dec_reg == '0);
    assign expire  = serve_reg && !fin && (slice_inc_reg == quantum_reg);
    // a full queue keeps the job running past its quantum
    assign requeue = serve_done && expire && !q_full;
    assign push    = (arr_done && !q_full) || requeue;
    assign push_entry = is_arr ? arr_entry : requeue_entry;
    assign ran_id  = serve_reg ? run_reg.job_id : '0;

    rrqs_chain
    #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    )
    u_chain
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (need_pop),
        .push_entry (push_entry),
        .head_entry (head_entry),
        .count      (q_count)
    );

    always_comb
    begin
        phase_next     = phase_reg;
        run_valid_next = run_valid_reg;
        run_next       = run_reg;
        slice_next     = slice_reg;
        time_next      = time_reg;
        wsum_next      = wsum_reg;
        rsum_next      = rsum_reg;
        done_next      = done_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;

        if (need_pop)
        begin
            run_valid_next = 1'b1;
            run_next       = head_entry;
        end

        if (serve_done && serve_reg)
        begin
            run_next.remaining = rem_dec_reg;
            run_next.started   = 1'b1;
            if (!run_reg.started)
            begin
                rsum_next = rsum_reg + resp_delta_reg;
            end
            priority if (fin)
            begin
                wsum_next      = wsum_reg + wait_delta_reg;
                done_next      = done_reg + rrqs_pkg::CNT_W'(1);
                run_valid_next = 1'b0;
                slice_next     = '0;
            end
            else if (expire)
            begin
                slice_next = '0;
                if (!q_full)
                begin
                    run_valid_next = 1'b0;
                end
            end
            else
            begin
                slice_next = slice_inc_reg;
            end
        end

        if (serve_done)
        begin
            time_next     = time_reg + rrqs_pkg::TIME_W'(1);
            m_tvalid_next = 1'b1;
            m_tuser_next  = serve_reg ? rrqs_pkg::STATUS_RAN : rrqs_pkg::STATUS_IDLE;
            m_tdata_next  = {6'b0, done_next, rsum_next, wsum_next, time_reg,
                             requeue, fin, ran_id};
        end
        else if (arr_done)
        begin
            m_tvalid_next = 1'b1;
            m_tuser_next  = q_full ? rrqs_pkg::STATUS_DROPPED : rrqs_pkg::STATUS_QUEUED;
            m_tdata_next  = {6'b0, done_reg, rsum_reg, wsum_reg, time_reg,
                             1'b0, 1'b0, rrqs_pkg::ID_W'(0)};
        end

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (in_fire)
                begin
                    phase_next = PH_PICK;
                end
            end
            PH_PICK:
            begin
                if (!is_arr)
                begin
                    phase_next = PH_SERVE;
                end
                else if (arr_done)
                begin
                    phase_next = in_fire ? PH_PICK : PH_IDLE;
                end
            end
            PH_SERVE:
            begin
                if (serve_done)
                begin
                    phase_next = in_fire ? PH_PICK : PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            quantum_reg   <= rrqs_pkg::QUANTUM_RESET;
            run_valid_reg <= 1'b0;
            run_reg       <= '0;
            slice_reg     <= '0;
            time_reg      <= '0;
            wsum_reg      <= '0;
            rsum_reg      <= '0;
            done_reg      <= '0;
            m_tvalid_reg  <= 1'b0;
            m_tdata_reg   <= '0;
            m_tuser_reg   <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            if (cfg_we)
            begin
                quantum_reg <= cfg_wdata;
            end
            run_valid_reg <= run_valid_next;
            run_reg       <= run_next;
            slice_reg     <= slice_next;
            time_reg      <= time_next;
            wsum_reg      <= wsum_next;
            rsum_reg      <= rsum_next;
            done_reg      <= done_next;
            m_tvalid_reg  <= m_tvalid_next;
            m_tdata_reg   <= m_tdata_next;
            m_tuser_reg   <= m_tuser_next;
        end
    end

    // item capture and pick-cycle arithmetic
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_op_reg    <= s_tuser;
            item_id_reg    <= s_tdata[15:0];
            item_burst_reg <= s_tdata[31:16];
        end
        if (phase_reg == PH_PICK)
        begin
            // no service at time zero, the picked job just waits in the slot
            serve_reg      <= have_job && (time_reg != '0);
            resp_delta_reg <= time_reg - sel_entry.arrival - rrqs_pkg::SUM_W'(1);
            wait_delta_reg <= time_reg - rrqs_pkg::SUM_W'(sel_entry.burst)
                              - sel_entry.arrival;
            rem_dec_reg    <= sel_entry.remaining - rrqs_pkg::BURST_W'(1);
            slice_inc_reg  <= slice_reg + rrqs_pkg::QNT_W'(1);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== rtl/rrqs_checker.sv =====
module rrqs_checker
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [135:0] m_tdata,
    input  logic [1:0]   m_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !m_tvalid)
        else $error("result valid during reset");

    // only a served tick names a job or raises a flag
    a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != rrqs_pkg::STATUS_RAN)
        |-> (m_tdata[15:0] == 16'd0) && !m_tdata[16] && !m_tdata[17])
        else $error("non-service result carries job fields");

    // a job cannot finish and be requeued on the same tick
    a_fin_pre: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[16] && m_tdata[17]))
        else $error("finished and preempted together");

endmodule

bind round_robin_quantum_scheduler rrqs_checker u_rrqs_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
